/* design/i2da_pkg.sv */
`default_nettype none
package i2da_pkg;

	localparam int unsigned MaxWidthDefault = 64;

	localparam logic [5:0] CharZero  = 6'd48;
	localparam logic [5:0] CharMinus = 6'd45;

	localparam logic [1:0] WidthCode16 = 2'd0;
	localparam logic [1:0] WidthCode32 = 2'd1;

	typedef struct packed {
		logic load;
		logic step;
		logic shift_digit;
	} dab_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_SKIP  = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_DIGIT = 5'b10000
	} state_t;

	// operand width in bits, capped at the widest supported operand
	function automatic logic [6:0] op_width(input logic [1:0] code, input logic [6:0] max_w);
		logic [6:0] w;
		case (code)
			WidthCode16: w = 7'd16;
			WidthCode32: w = 7'd32;
			default:     w = 7'd64;
		endcase
		if (w > max_w) begin
			w = max_w;
		end
		return w;
	endfunction

endpackage
`default_nettype wire

/* design/integer_to_decimal_ascii_core.sv */
`default_nettype none
// Converts a 16, 32 or 64 bit integer, unsigned or two's complement, into its
// decimal ASCII text, one character per output transaction, most significant
// first, with a leading '-' for negative values and last_char on the final
// digit; zero gives a single '0', and operand widths above MAX_WIDTH are capped.
// One number at a time: after acceptance a shift-and-add-three unit runs over
// all MAX_WIDTH operand bits (one operand bit per cycle), then leading zero digits
// are dropped at one per cycle (up to NDIG-1 of them, NDIG = 20 at MAX_WIDTH 64),
// then one character leaves per cycle when the output is not stalled; in_stall
// stays high until the final digit has been loaded into the output register.
module integer_to_decimal_ascii_core import i2da_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] value,
	input  wire logic [1:0]  width_code,
	input  wire logic        is_signed,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [5:0]  char_code,
	output logic             last_char
);

	localparam int unsigned NDIG  = (MAX_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned DigW  = $clog2(NDIG);
	localparam int unsigned IterW = $clog2(MAX_WIDTH);

	state_t               state_q;
	logic [IterW-1:0]     iter_q;
	logic [DigW-1:0]      dcnt_q;
	logic                 neg_q;
	logic                 out_valid_q;
	logic [5:0]           char_q;
	logic                 last_q;

	logic                 in_acc;
	logic                 slot_free;
	logic [6:0]           w;
	logic [63:0]          mask;
	logic [63:0]          v;
	logic [5:0]           sidx;
	logic                 neg;
	logic [63:0]          mag;
	logic [3:0]           top_digit;
	dab_ctl_t             ctl;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// operand width, masking and magnitude
	always_comb begin
		w = op_width(width_code, 7'(MAX_WIDTH));
		for (int i = 0; i < 64; i++) begin
			mask[i] = (7'(i) < w);
		end
		v    = value & mask;
		sidx = 6'(w - 7'd1);
		neg  = is_signed && v[sidx];
		mag  = neg ? ((~v + 64'd1) & mask) : v;
	end

	always_comb begin
		ctl.load        = in_acc;
		ctl.step        = (state_q == ST_CONV);
		ctl.shift_digit = ((state_q == ST_SKIP) && (top_digit == 4'd0) && (dcnt_q != '0))
			|| ((state_q == ST_DIGIT) && slot_free);
	end

	i2da_dabble #(
		.MAX_WIDTH(MAX_WIDTH),
		.NDIG     (NDIG)
	) u_dabble (
		.clk      (clk),
		.ctl      (ctl),
		.load_mag (mag[MAX_WIDTH-1:0]),
		.top_digit(top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			dcnt_q      <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (((state_q == ST_SIGN) || (state_q == ST_DIGIT)) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						neg_q   <= neg;
						iter_q  <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (iter_q == IterW'(MAX_WIDTH - 1)) begin
						dcnt_q  <= DigW'(NDIG - 1);
						state_q <= ST_SKIP;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_SKIP: begin
					if ((top_digit == 4'd0) && (dcnt_q != '0)) begin
						dcnt_q <= dcnt_q - 1'b1;
					end else if (neg_q) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (slot_free) begin
						if (dcnt_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							dcnt_q <= dcnt_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_SIGN) && slot_free) begin
			char_q <= CharMinus;
			last_q <= 1'b0;
		end else if ((state_q == ST_DIGIT) && slot_free) begin
			char_q <= CharZero + {2'b00, top_digit};
			last_q <= (dcnt_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule
`default_nettype wire

/* design/i2da_dabble.sv */
`default_nettype none
module i2da_dabble import i2da_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MaxWidthDefault,
	parameter int unsigned NDIG      = 20
) (
	input  wire logic                 clk,
	input  wire dab_ctl_t             ctl,
	input  wire logic [MAX_WIDTH-1:0] load_mag,
	output logic      [3:0]           top_digit
);

	localparam int unsigned BcdW = NDIG * 4;

	logic [MAX_WIDTH-1:0] bin_q;
	logic [BcdW-1:0]      bcd_q;
	logic [BcdW-1:0]      bcd_adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= load_mag;
			bcd_q <= '0;
		end else if (ctl.step) begin
			bin_q <= {bin_q[MAX_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BcdW-2:0], bin_q[MAX_WIDTH-1]};
		end else if (ctl.shift_digit) begin
			bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BcdW-1 -: 4];

endmodule
`default_nettype wire
